[rtl/core/rfd_pkg.sv]
// Package for the response frame deframer.
// Holds frame constants, parser phases, status kinds and the result record.
// No dependencies.
package rfd_pkg;

  localparam logic [7:0] HdrFirst  = 8'h78;
  localparam logic [7:0] HdrSecond = 8'h07;
  localparam logic [7:0] EndMark   = 8'h79;
  localparam logic [7:0] AnyCmd    = 8'hFF;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegWantMajor = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWantMinor = CfgIdxW'(1);

  typedef enum logic [2:0] {
    PhHunt0 = 3'd0,
    PhHunt1 = 3'd1,
    PhMajor = 3'd2,
    PhMinor = 3'd3,
    PhLen   = 3'd4,
    PhData  = 3'd5,
    PhSum   = 3'd6,
    PhEnd   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindGood    = 2'd1,
    KindBadSum  = 2'd2,
    KindBadEnd  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] cmd_major;
    logic [7:0] cmd_minor;
    logic [7:0] payload_len;
    logic       frame_end;
  } result_t;

endpackage

[rtl/core/response_frame_deframer.sv]
// Top level of the response frame deframer.
// Depends on rfd_pkg, rfd_cfg_regs, rfd_parser and rfd_out_reg.
//
// Takes one received byte per transaction and hunts for the header 0x78 0x07, then
// reads the two command bytes, a length, the payload, an 8-bit additive checksum and
// the end byte 0x79. Frames whose commands miss the filter registers (both 0xFF
// accepts all) are consumed silently. A passing frame yields one transaction per
// payload byte and one status transaction with tlast high. The parser updates its phase
// and sum in the cycle of acceptance and the result lands in one output register, so a
// byte is taken each cycle unless that register is held.
module response_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] cmd_major, [31:24] cmd_minor,
  // [39:32] payload_len
  output logic [39:0]                 m_axis_tdata,
  output logic [1:0]                  m_axis_tuser,  // [1:0] kind
  output logic                        m_axis_tlast   // frame_end
);

  logic             accept;
  logic             space;
  logic [7:0]       want_major;
  logic [7:0]       want_minor;
  logic             res_valid;
  rfd_pkg::result_t res;
  rfd_pkg::result_t out_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  rfd_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (cfg_valid_i),
    .wr_index_i   (cfg_index_i),
    .wr_data_i    (cfg_data_i),
    .want_major_o (want_major),
    .want_minor_o (want_minor)
  );

  rfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (s_axis_tdata),
    .want_major_i (want_major),
    .want_minor_i (want_minor),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {out_res.payload_len, out_res.cmd_minor, out_res.cmd_major,
                         out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.frame_end;

endmodule

[rtl/core/rfd_cfg_regs.sv]
// Command filter registers of the response frame deframer.
// Depends on rfd_pkg for register indexes and reset values.
module rfd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [rfd_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [7:0]                 wr_data_i,
  output logic [7:0]                 want_major_o,
  output logic [7:0]                 want_minor_o
);

  logic [7:0] want_major_q, want_major_d;
  logic [7:0] want_minor_q, want_minor_d;

  always_comb begin
    want_major_d = want_major_q;
    want_minor_d = want_minor_q;
    if (wr_en_i) begin
      case (wr_index_i)
        rfd_pkg::RegWantMajor: want_major_d = wr_data_i;
        rfd_pkg::RegWantMinor: want_minor_d = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_major_q <= rfd_pkg::AnyCmd;
      want_minor_q <= rfd_pkg::AnyCmd;
    end else begin
      want_major_q <= want_major_d;
      want_minor_q <= want_minor_d;
    end
  end

  assign want_major_o = want_major_q;
  assign want_minor_o = want_minor_q;

endmodule

[rtl/core/rfd_parser.sv]
// Frame parser of the response frame deframer: phase machine, held fields, checksum.
// Depends on rfd_pkg; produces at most one result record per accepted byte.
module rfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       want_major_i,
  input  logic [7:0]       want_minor_i,
  output logic             res_valid_o,
  output rfd_pkg::result_t res_o
);

  rfd_pkg::phase_e phase_q, phase_d;
  logic [7:0] major_q, major_d;
  logic [7:0] minor_q, minor_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] rx_sum_q, rx_sum_d;
  logic       wanted_q, wanted_d;
  logic [7:0] sum_add;
  logic [7:0] count_inc;

  assign sum_add   = sum_q + rx_byte_i;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    major_d     = major_q;
    minor_d     = minor_q;
    len_d       = len_q;
    count_d     = count_q;
    sum_d       = sum_q;
    rx_sum_d    = rx_sum_q;
    wanted_d    = wanted_q;
    res_valid_o = 1'b0;
    res_o.kind        = rfd_pkg::KindPayload;
    res_o.data_byte   = 8'd0;
    res_o.byte_index  = 8'd0;
    res_o.cmd_major   = major_q;
    res_o.cmd_minor   = minor_q;
    res_o.payload_len = len_q;
    res_o.frame_end   = 1'b0;
    if (accept_i) begin
      case (phase_q)
        rfd_pkg::PhHunt0: begin
          if (rx_byte_i == rfd_pkg::HdrFirst) phase_d = rfd_pkg::PhHunt1;
        end
        rfd_pkg::PhHunt1: begin
          if (rx_byte_i == rfd_pkg::HdrSecond) phase_d = rfd_pkg::PhMajor;
          else if (rx_byte_i == rfd_pkg::HdrFirst) phase_d = rfd_pkg::PhHunt1;
          else phase_d = rfd_pkg::PhHunt0;
        end
        rfd_pkg::PhMajor: begin
          major_d = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = rfd_pkg::PhMinor;
        end
        rfd_pkg::PhMinor: begin
          minor_d  = rx_byte_i;
          sum_d    = sum_add;
          wanted_d = ((want_major_i == rfd_pkg::AnyCmd) && (want_minor_i == rfd_pkg::AnyCmd))
                  || ((major_q == want_major_i) && (rx_byte_i == want_minor_i));
          phase_d  = rfd_pkg::PhLen;
        end
        rfd_pkg::PhLen: begin
          len_d   = rx_byte_i;
          sum_d   = sum_add;
          count_d = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? rfd_pkg::PhSum : rfd_pkg::PhData;
        end
        rfd_pkg::PhData: begin
          sum_d            = sum_add;
          res_valid_o      = wanted_q;
          res_o.data_byte  = rx_byte_i;
          res_o.byte_index = count_q;
          count_d          = count_inc;
          if (count_inc == len_q) phase_d = rfd_pkg::PhSum;
        end
        rfd_pkg::PhSum: begin
          rx_sum_d = rx_byte_i;
          phase_d  = rfd_pkg::PhEnd;
        end
        rfd_pkg::PhEnd: begin
          res_valid_o     = wanted_q;
          res_o.frame_end = 1'b1;
          if (rx_byte_i != rfd_pkg::EndMark) res_o.kind = rfd_pkg::KindBadEnd;
          else if (sum_q == rx_sum_q) res_o.kind = rfd_pkg::KindGood;
          else res_o.kind = rfd_pkg::KindBadSum;
          phase_d = (rx_byte_i == rfd_pkg::HdrFirst) ? rfd_pkg::PhHunt1 : rfd_pkg::PhHunt0;
        end
        default: phase_d = rfd_pkg::PhHunt0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rfd_pkg::PhHunt0;
      major_q  <= 8'd0;
      minor_q  <= 8'd0;
      len_q    <= 8'd0;
      count_q  <= 8'd0;
      sum_q    <= 8'd0;
      rx_sum_q <= 8'd0;
      wanted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      len_q    <= len_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      rx_sum_q <= rx_sum_d;
      wanted_q <= wanted_d;
    end
  end

endmodule

[rtl/core/rfd_out_reg.sv]
// Result register of the response frame deframer; parts the input and output handshakes.
// Depends on rfd_pkg for the result record.
module rfd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  rfd_pkg::result_t res_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output rfd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  rfd_pkg::result_t res_q, res_d;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q && !ready_i;
    res_d   = res_q;
    if (load_i) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
